[rtl/slcbs_pkg.sv]
// ----------------------------------------------------------------------------
// slcbs_pkg
// Shared constants and types of the slice label count and bound search block.
// ----------------------------------------------------------------------------
package slcbs_pkg;

	localparam int MAX_SIZE    = 256;
	localparam int MAX_LABELS  = 16;
	localparam int COUNT_WIDTH = 17;
	localparam int AXES        = 3;
	localparam int SLICE_W     = 8;
	localparam int LABEL_W     = 4;
	localparam int AXIS_W      = 2;
	localparam int SIZE_W      = 9;
	localparam int LIMIT_W     = 5;
	localparam int STORE_DEPTH = AXES * MAX_SIZE * MAX_LABELS;
	localparam int ADDR_W      = AXIS_W + SLICE_W + LABEL_W;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 24;
	localparam int CFG_IDX_W   = 2;

	localparam logic [SIZE_W-1:0]      SIZE_RESET  = SIZE_W'(MAX_SIZE);
	localparam logic [LIMIT_W-1:0]     LIMIT_RESET = LIMIT_W'(MAX_LABELS);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
	localparam logic [ADDR_W-1:0]      CLEAR_LAST  = ADDR_W'(STORE_DEPTH - 1);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_VOXEL = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [AXIS_W-1:0] {
		AX_X    = 2'd0,
		AX_Y    = 2'd1,
		AX_Z    = 2'd2,
		AX_NONE = 2'd3
	} axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X      = 2'd0,
		REG_SIZE_Y      = 2'd1,
		REG_SIZE_Z      = 2'd2,
		REG_LABEL_LIMIT = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		RES_FOUND    = 3'd0,
		RES_BAD      = 3'd1,
		RES_HAS      = 3'd2,
		RES_NO_LOWER = 3'd3,
		RES_NO_UPPER = 3'd4
	} res_code_t;

	typedef enum logic [2:0] {
		RA_VOX_X,
		RA_VOX_Y,
		RA_VOX_Z,
		RA_SLICE,
		RA_CURSOR
	} ra_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_VOX_Y,
		S_VOX_Z,
		S_VOX_W,
		S_Q_SLICE,
		S_DN_RD,
		S_DN_CK,
		S_UP_RD,
		S_UP_CK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic      capture;
		logic      rd_en;
		ra_sel_t   ra_sel;
		logic      vox_wr;
		logic      clr_wr;
		logic      cur_dn;
		logic      cur_up;
		logic      cur_dec;
		logic      cur_inc;
		logic      lo_load;
		logic      res_load;
		res_code_t res_code;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      vox_ok;
		logic      q_ok;
		logic      hit;
		logic      cur_zero;
		logic      cur_top;
		logic      clr_last;
		logic      out_free;
	} dp_sts_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] r;
		r = raw;
		if (raw == '0) begin
			r = SIZE_W'(1);
		end else if (raw > SIZE_W'(MAX_SIZE)) begin
			r = SIZE_W'(MAX_SIZE);
		end
		return r;
	endfunction

	function automatic logic [LIMIT_W-1:0] eff_labels(input logic [LIMIT_W-1:0] raw);
		logic [LIMIT_W-1:0] r;
		r = raw;
		if (raw == '0) begin
			r = LIMIT_W'(1);
		end else if (raw > LIMIT_W'(MAX_LABELS)) begin
			r = LIMIT_W'(MAX_LABELS);
		end
		return r;
	endfunction

endpackage

[rtl/slcbs_ram.sv]
// ----------------------------------------------------------------------------
// slcbs_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module slcbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/slcbs_dp.sv]
// ----------------------------------------------------------------------------
// slcbs_dp
// Datapath: configuration registers, captured command, count store, scan
// cursor and result register.
// ----------------------------------------------------------------------------
module slcbs_dp
	import slcbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts
);

	logic [SIZE_W-1:0]      size_x_q, size_y_q, size_z_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic [1:0]             cmd_q;
	logic [SLICE_W-1:0]     vx_q, vy_q, vz_q, sl_q;
	logic [LABEL_W-1:0]     lab_q;
	logic [AXIS_W-1:0]      ax_q;
	logic [SLICE_W-1:0]     cur_q, lo_q;
	logic [ADDR_W-1:0]      clr_q, raddr_q, rd_addr, wr_addr;
	logic [COUNT_WIDTH-1:0] rd_data, wr_data;
	logic                   wr_en;
	logic                   out_valid_q;
	logic [2:0]             res_status_q;
	logic [SLICE_W-1:0]     res_lower_q, res_upper_q;
	logic [SIZE_W-1:0]      ex, ey, ez, n_ax, n_m1;
	logic [LIMIT_W-1:0]     el;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SIZE_X:      size_x_q <= cfg_data;
				REG_SIZE_Y:      size_y_q <= cfg_data;
				REG_SIZE_Z:      size_z_q <= cfg_data;
				REG_LABEL_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= s_tdata[1:0];
			vx_q  <= s_tdata[9:2];
			vy_q  <= s_tdata[17:10];
			vz_q  <= s_tdata[25:18];
			lab_q <= s_tdata[29:26];
			ax_q  <= s_tdata[31:30];
			sl_q  <= s_tdata[39:32];
		end
		if (cmd.cur_dn) begin
			cur_q <= sl_q - SLICE_W'(1);
		end else if (cmd.cur_up) begin
			cur_q <= sl_q + SLICE_W'(1);
		end else if (cmd.cur_dec) begin
			cur_q <= cur_q - SLICE_W'(1);
		end else if (cmd.cur_inc) begin
			cur_q <= cur_q + SLICE_W'(1);
		end
		if (cmd.lo_load) begin
			lo_q <= cur_q;
		end
		if (cmd.rd_en) begin
			raddr_q <= rd_addr;
		end
	end

	assign ex = eff_size(size_x_q);
	assign ey = eff_size(size_y_q);
	assign ez = eff_size(size_z_q);
	assign el = eff_labels(limit_q);

	always_comb begin
		unique case (axis_t'(ax_q))
			AX_X:    n_ax = ex;
			AX_Y:    n_ax = ey;
			default: n_ax = ez;
		endcase
	end
	assign n_m1 = n_ax - SIZE_W'(1);

	always_comb begin
		unique case (cmd.ra_sel)
			RA_VOX_X:  rd_addr = {AX_X, vx_q, lab_q};
			RA_VOX_Y:  rd_addr = {AX_Y, vy_q, lab_q};
			RA_VOX_Z:  rd_addr = {AX_Z, vz_q, lab_q};
			RA_SLICE:  rd_addr = {ax_q, sl_q, lab_q};
			default:   rd_addr = {ax_q, cur_q, lab_q};
		endcase
	end

	assign wr_en   = cmd.vox_wr | cmd.clr_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : raddr_q;
	assign wr_data = cmd.clr_wr ? '0 :
		(rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_WIDTH'(1);

	slcbs_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= (clr_q == CLEAR_LAST) ? '0 : clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_lower_q  <= (cmd.res_code == RES_FOUND) ? lo_q : '0;
			res_upper_q  <= (cmd.res_code == RES_FOUND) ? cur_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, res_upper_q, res_lower_q, res_status_q};

	assign sts.cmd      = cmd_code_t'(cmd_q);
	assign sts.vox_ok   = ({1'b0, vx_q} < ex) && ({1'b0, vy_q} < ey) &&
		({1'b0, vz_q} < ez) && ({1'b0, lab_q} < el);
	assign sts.q_ok     = (axis_t'(ax_q) != AX_NONE) && ({1'b0, lab_q} < el) &&
		(sl_q != '0) && ({1'b0, sl_q} < n_m1);
	assign sts.hit      = (rd_data != '0);
	assign sts.cur_zero = (cur_q == '0);
	assign sts.cur_top  = ({1'b0, cur_q} == n_m1);
	assign sts.clr_last = (clr_q == CLEAR_LAST);
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

[rtl/slcbs_ctrl.sv]
// ----------------------------------------------------------------------------
// slcbs_ctrl
// Controller: sequences clearing, voxel count updates and bound scans.
// ----------------------------------------------------------------------------
module slcbs_ctrl
	import slcbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t    state_q, state_d;
	res_code_t code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.cmd)
					CMD_CLEAR: state_d = S_CLEAR;
					CMD_VOXEL: begin
						if (sts.vox_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = RA_VOX_X;
							state_d    = S_VOX_Y;
						end else begin
							state_d = S_IDLE;
						end
					end
					CMD_QUERY: begin
						if (sts.q_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = RA_SLICE;
							state_d    = S_Q_SLICE;
						end else begin
							cmd.res_code = RES_BAD;
							state_d      = S_EMIT;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_VOX_Y: begin
				cmd.vox_wr = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = RA_VOX_Y;
				state_d    = S_VOX_Z;
			end
			S_VOX_Z: begin
				cmd.vox_wr = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = RA_VOX_Z;
				state_d    = S_VOX_W;
			end
			S_VOX_W: begin
				cmd.vox_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_Q_SLICE: begin
				if (sts.hit) begin
					state_d = S_EMIT;
				end else begin
					cmd.cur_dn = 1'b1;
					state_d    = S_DN_RD;
				end
			end
			S_DN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = RA_CURSOR;
				state_d    = S_DN_CK;
			end
			S_DN_CK: begin
				priority if (sts.hit) begin
					cmd.lo_load = 1'b1;
					cmd.cur_up  = 1'b1;
					state_d     = S_UP_RD;
				end else if (sts.cur_zero) begin
					state_d = S_EMIT;
				end else begin
					cmd.cur_dec = 1'b1;
					state_d     = S_DN_RD;
				end
			end
			S_UP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = RA_CURSOR;
				state_d    = S_UP_CK;
			end
			S_UP_CK: begin
				priority if (sts.hit || sts.cur_top) begin
					state_d = S_EMIT;
				end else begin
					cmd.cur_inc = 1'b1;
					state_d     = S_UP_RD;
				end
			end
			S_EMIT: begin
				cmd.res_code = code_q;
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// The result code is registered as each decision state is left, so the
	// emit state sees the outcome of the last check that led into it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= RES_BAD;
		end else begin
			unique case (state_q)
				S_DECODE:  code_q <= RES_BAD;
				S_Q_SLICE: code_q <= RES_HAS;
				S_DN_CK:   code_q <= RES_NO_LOWER;
				S_UP_CK:   code_q <= sts.hit ? RES_FOUND : RES_NO_UPPER;
				default:   code_q <= code_q;
			endcase
		end
	end

endmodule

[rtl/slice_label_count_bound_search.sv]
// ----------------------------------------------------------------------------
// slice_label_count_bound_search
// Per-axis, per-slice label counts with nearest bound search.
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel; a beat is taken when s_tvalid and s_tready
// are high. A clear zeroes all 12288 counts, one per cycle; with its capture
// and decode it holds the input until the sweep ends. The same sweep runs
// after reset, and s_tready stays low until it ends. A voxel beat runs as
// capture, a decode step that issues the first read, then read-modify-write
// steps on the single count memory, overlapped so that one count is written
// while the next is read. A voxel out of range and an unused command go back
// to idle after decode. A query gives one result beat on the m_ channel once
// its downward and upward scans, if any, are done; each slice visited costs a
// memory read and a check. A bad request goes from decode straight to its beat.
// A result waits in the output register while m_tready is low; a following
// query runs its scan and then holds, with s_tready low, until that register
// is free. Configuration writes are taken on any cycle.
// ----------------------------------------------------------------------------
module slice_label_count_bound_search
	import slcbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// command, voxel_x, voxel_y, voxel_z, label_value, axis, slice_index
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status, lower_slice, upper_slice, zero fill
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	slcbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	slcbs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
